>>> design/positional_list_insert_delete_assert.svh
// Assertion macros for the positional list block.
// Used by the datapath; no other dependencies.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define PL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/plist_pkg.sv
// Package for the positional list block: item types, codes, control structs.
// No dependencies.
package plist_pkg;

    localparam int P_CAPACITY = 32;
    localparam int POS_W      = 8;

    // opcodes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_DEL_POS   = 3'd5;
    localparam logic [2:0] OP_DUMP      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]        opcode;
        logic signed [31:0] value;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] element;
        logic [6:0]        count;
        logic              last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic dump_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic dump_go;
        logic dump_last;
    } t_stat;

endpackage

>>> design/plist_ctrl.sv
// Controller for the positional list: sequences accept, execute and dump.
// Depends on plist_pkg.
module plist_ctrl
    import plist_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.dump_go ? S_DUMP : S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.dump_step = 1'b1;
                    if (i_stat.dump_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

>>> design/plist_dp.sv
// Datapath for the positional list: shifting cell chain, count, output register.
// Depends on plist_pkg and the assertion macro header.
`include "positional_list_insert_delete_assert.svh"
module plist_dp
    import plist_pkg::*;
#(
    parameter int CAPACITY = P_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [31:0] r_cells [CAPACITY];
    logic signed [31:0] n_cells [CAPACITY];
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_dump_idx;
    t_in_item           r_in;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [POS_W-1:0] cnt8;
    logic [POS_W:0]   pos9;
    logic             full, empty;
    logic             do_ins, do_del, do_rot;
    logic [POS_W-1:0] ins_idx, del_idx;
    logic [1:0]       op_status;
    logic             dump_last;

    assign cnt8  = POS_W'(r_count);
    assign pos9  = {1'b0, r_in.position};
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    // decode the latched item into a shift command and a status
    always_comb begin
        op_status = ST_OK;
        ins_idx   = '0;
        del_idx   = '0;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        unique case (r_in.opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                if (r_in.opcode == OP_INS_FRONT)     ins_idx = '0;
                else if (r_in.opcode == OP_INS_BACK) ins_idx = cnt8;
                else                                 ins_idx = r_in.position - POS_W'(1);
                if (full) begin
                    op_status = ST_FULL;
                end else if (r_in.opcode == OP_INS_POS &&
                             (r_in.position == '0 ||
                              pos9 > ({1'b0, cnt8} + (POS_W+1)'(1)))) begin
                    op_status = ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                if (r_in.opcode == OP_DEL_FRONT)     del_idx = '0;
                else if (r_in.opcode == OP_DEL_BACK) del_idx = cnt8 - POS_W'(1);
                else                                 del_idx = r_in.position - POS_W'(1);
                if (empty) begin
                    op_status = ST_EMPTY;
                end else if (r_in.opcode == OP_DEL_POS &&
                             (r_in.position == '0 || pos9 > {1'b0, cnt8})) begin
                    op_status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                end
            end
            OP_DUMP:  op_status = ST_EMPTY;  // only emitted when the list is empty
            default:  op_status = ST_OK;
        endcase
    end

    assign do_rot    = i_cmd.dump_step;
    assign dump_last = ((CW'(r_dump_idx) + CW'(1)) == r_count);

    // per-cell next value: insert shifts back, delete shifts forward,
    // dump rotates the occupied cells so the front is always cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] prev_v, next_v;
        if (g == 0) begin : g_first
            assign prev_v = r_in.value;
        end else begin : g_prev
            assign prev_v = r_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_lastc
            assign next_v = r_cells[g];
        end else begin : g_next
            assign next_v = r_cells[g+1];
        end
        always_comb begin
            n_cells[g] = r_cells[g];
            if (i_cmd.exec && do_ins && POS_W'(g) >= ins_idx) begin
                n_cells[g] = (POS_W'(g) == ins_idx) ? r_in.value : prev_v;
            end else if (i_cmd.exec && do_del && POS_W'(g) >= del_idx) begin
                n_cells[g] = next_v;
            end else if (do_rot && CW'(g) < r_count) begin
                n_cells[g] = ((CW'(g) + CW'(1)) == r_count) ? r_cells[0] : next_v;
            end
        end
        always_ff @(posedge i_clk) begin
            r_cells[g] <= n_cells[g];
        end
    end

    // latched item and dump index
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) r_in <= i_in_item;
        if (i_cmd.exec)           r_dump_idx <= '0;
        else if (i_cmd.dump_step) r_dump_idx <= r_dump_idx + IW'(1);
    end

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec && do_ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.exec && do_del) begin
            r_count <= r_count - CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && !o_stat.dump_go) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !o_stat.dump_go) begin
            r_out.status  <= op_status;
            r_out.element <= '0;
            r_out.last    <= 1'b1;
            if (do_ins)      r_out.count <= 7'(r_count + CW'(1));
            else if (do_del) r_out.count <= 7'(r_count - CW'(1));
            else             r_out.count <= 7'(r_count);
        end else if (i_cmd.dump_step) begin
            r_out.status  <= ST_OK;
            r_out.element <= r_cells[0];
            r_out.count   <= 7'(r_count);
            r_out.last    <= dump_last;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.dump_go   = (r_in.opcode == OP_DUMP) && !empty;
    assign o_stat.dump_last = dump_last;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

    // checks
    `PL_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `PL_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !i_cmd.exec, $stable(r_count))
    `PL_ASSERT_IMPLY(a_dump_nonempty, i_clk, i_rst_n, i_cmd.dump_step, !empty)
    `PL_ASSERT_NEXT(a_dump_last, i_clk, i_rst_n, i_cmd.dump_step && dump_last,
                    o_out_valid && o_out_item.last)

endmodule

>>> design/positional_list_insert_delete.sv
// Positional list: an item is accepted in S_IDLE and executed in S_EXEC when the
// output is free, and a single-result item's result goes to the output register.
// No new item is taken until the last one is done; a dump emits one element per
// rotation step of the cell chain. Output stalls hold the execute and dump steps.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
// Top level: wires the controller to the datapath. Depends on plist_pkg.
module positional_list_insert_delete
    import plist_pkg::*;
#(
    parameter int CAPACITY = P_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    plist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
